/* src/bucketed_transposition_table_macros.svh */
// Assertion macros shared by the transposition table modules
`ifndef BUCKETED_TRANSPOSITION_TABLE_MACROS_SVH
`define BUCKETED_TRANSPOSITION_TABLE_MACROS_SVH

`ifndef SYNTHESIS

`define BTT_ASSERT(name, clk, rstn, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
		else $error(msg);

`define BTT_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`else

`define BTT_ASSERT(name, clk, rstn, expr, msg)

`define BTT_ASSERT_NEXT(name, clk, rstn, ante, cons, msg)

`endif

`endif

/* src/btt_pkg.sv */
// Types and constants of the bucketed transposition table
`default_nettype none

package btt_pkg;

	localparam logic OP_PROBE = 1'b0;
	localparam logic OP_STORE = 1'b1;

	localparam logic [1:0] EXACT_BOUND = 2'd3;

	localparam logic signed [10:0] EMPTY_SCORE  = -11'sd1000;
	localparam logic [8:0]         DEPTH_MARGIN = 9'd3;

	localparam int   REG_ADDR_W            = 3;
	localparam logic REG_SEARCH_GENERATION = 1'b0;

	typedef logic signed [10:0] way_score_t;

	typedef struct packed {
		logic [5:0]  gen;
		logic [1:0]  bound;
		logic [7:0]  depth;
		logic [15:0] eval;
		logic [15:0] score;
		logic [15:0] move;
	} entry_data_t;

	typedef struct packed {
		logic               op;
		logic [63:0]        position_key;
		logic [15:0]        best_move;
		logic signed [15:0] search_score;
		logic signed [15:0] static_eval;
		logic [7:0]         search_depth;
		logic [1:0]         bound_kind;
	} req_word_t;

	typedef struct packed {
		logic               hit;
		logic [15:0]        found_move;
		logic signed [15:0] found_score;
		logic signed [15:0] found_eval;
		logic [7:0]         found_depth;
		logic [1:0]         found_bound;
	} rsp_word_t;

	typedef struct packed {
		logic capture;
		logic commit;
		logic clr_en;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_status_t;

endpackage

`default_nettype wire

/* src/btt_if.sv */
// Request and response channel interfaces of the transposition table
`default_nettype none

interface btt_req_if;
	logic               valid;
	logic               ready;
	logic               op;
	logic [63:0]        position_key;
	logic [15:0]        best_move;
	logic signed [15:0] search_score;
	logic signed [15:0] static_eval;
	logic [7:0]         search_depth;
	logic [1:0]         bound_kind;

	modport source (
		output valid, op, position_key, best_move, search_score, static_eval,
			search_depth, bound_kind,
		input ready
	);
	modport sink (
		input valid, op, position_key, best_move, search_score, static_eval,
			search_depth, bound_kind,
		output ready
	);
endinterface

interface btt_rsp_if;
	logic               valid;
	logic               ready;
	logic               hit;
	logic [15:0]        found_move;
	logic signed [15:0] found_score;
	logic signed [15:0] found_eval;
	logic [7:0]         found_depth;
	logic [1:0]         found_bound;

	modport source (
		output valid, hit, found_move, found_score, found_eval, found_depth, found_bound,
		input ready
	);
	modport sink (
		input valid, hit, found_move, found_score, found_eval, found_depth, found_bound,
		output ready
	);
endinterface

`default_nettype wire

/* src/btt_ram.sv */
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module btt_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* src/btt_ctrl.sv */
// Controller of the transposition table: clearing pass, accept, commit
`default_nettype none
`include "bucketed_transposition_table_macros.svh"

module btt_ctrl #(
	parameter int BUCKET_INDEX_BITS = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  btt_pkg::dp_status_t          status,
	output btt_pkg::ctrl_cmd_t           cmd,
	output logic [BUCKET_INDEX_BITS-1:0] clr_addr
);
	import btt_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_LOOK  = 2'd2;

	logic [1:0]                   state_q;
	logic [1:0]                   state_d;
	logic [BUCKET_INDEX_BITS-1:0] clr_addr_q;

	assign req_ready   = (state_q == ST_IDLE);
	assign cmd.capture = (state_q == ST_IDLE) && req_valid;
	assign cmd.commit  = (state_q == ST_LOOK) && !status.out_busy;
	assign cmd.clr_en  = (state_q == ST_CLEAR);
	assign clr_addr    = clr_addr_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (&clr_addr_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (!status.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	`BTT_ASSERT_NEXT(a_capture_look, clk, arst_n, cmd.capture, state_q == ST_LOOK, "accepted word did not enter compare")
	`BTT_ASSERT_NEXT(a_commit_idle, clk, arst_n, cmd.commit, state_q == ST_IDLE, "commit did not return to idle")
	`BTT_ASSERT_NEXT(a_look_hold, clk, arst_n, (state_q == ST_LOOK) && !cmd.commit, state_q == ST_LOOK, "stalled compare left its state")

endmodule

`default_nettype wire

/* src/btt_dpath.sv */
// Datapath of the transposition table: way memories, match, victim select, result
`default_nettype none
`include "bucketed_transposition_table_macros.svh"

module btt_dpath #(
	parameter int BUCKET_INDEX_BITS = 10,
	parameter int WAYS              = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  btt_pkg::req_word_t           req_word,
	input  logic [5:0]                   gen,
	input  btt_pkg::ctrl_cmd_t           cmd,
	input  logic [BUCKET_INDEX_BITS-1:0] clr_addr,
	output btt_pkg::rsp_word_t           rsp_word,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output btt_pkg::dp_status_t          status
);
	import btt_pkg::*;

	localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int NUM_BUCKETS = 1 << BUCKET_INDEX_BITS;
	localparam int SLOT_W      = 128;

	req_word_t                    req_q;
	rsp_word_t                    rsp_q;
	logic                         rsp_valid_q;

	logic [SLOT_W-1:0]            rd_slot [WAYS];
	entry_data_t                  d_w     [WAYS];
	logic [63:0]                  chk_w   [WAYS];
	logic [5:0]                   age_w   [WAYS];
	way_score_t                   score_w [WAYS];
	logic [WAYS-1:0]              match;
	logic [WAYS-1:0]              way_we;

	logic                         found;
	logic [WAY_W-1:0]             chosen;
	way_score_t                   worst;
	entry_data_t                  m_d;
	logic                         p_hit;
	entry_data_t                  p_d;
	logic                         skip;
	logic                         store_write;
	logic [15:0]                  new_move;
	entry_data_t                  nd;
	logic [BUCKET_INDEX_BITS-1:0] wr_addr;
	logic [SLOT_W-1:0]            wr_slot;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_word;
		end
	end

	for (genvar w = 0; w < WAYS; w++) begin : g_way
		btt_ram #(
			.WIDTH(SLOT_W),
			.DEPTH(NUM_BUCKETS)
		) u_way_ram (
			.clk  (clk),
			.we   (way_we[w]),
			.waddr(wr_addr),
			.wdata(wr_slot),
			.re   (cmd.capture),
			.raddr(req_word.position_key[BUCKET_INDEX_BITS-1:0]),
			.rdata(rd_slot[w])
		);

		assign d_w[w]     = rd_slot[w][63:0];
		assign chk_w[w]   = rd_slot[w][127:64];
		assign match[w]   = ((chk_w[w] ^ rd_slot[w][63:0]) == req_q.position_key);
		assign age_w[w]   = gen - d_w[w].gen;
		assign score_w[w] = (rd_slot[w][63:0] == 64'd0) ? EMPTY_SCORE :
			$signed({3'b000, d_w[w].depth}) - $signed({2'b00, age_w[w], 3'b000});
		assign way_we[w]  = cmd.clr_en ||
			(cmd.commit && store_write && (chosen == WAY_W'(w)));
	end

	always_comb begin
		found  = 1'b0;
		chosen = '0;
		worst  = '0;
		m_d    = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (!found) begin
				if (match[w]) begin
					found  = 1'b1;
					chosen = WAY_W'(w);
					m_d    = d_w[w];
				end else if ((w == 0) || (score_w[w] < worst)) begin
					worst  = score_w[w];
					chosen = WAY_W'(w);
				end
			end
		end
	end

	always_comb begin
		p_hit = 1'b0;
		p_d   = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (!p_hit && match[w] && (d_w[w] != '0)) begin
				p_hit = 1'b1;
				p_d   = d_w[w];
			end
		end
	end

	assign skip = found && (req_q.bound_kind != EXACT_BOUND) &&
		(({1'b0, req_q.search_depth} + DEPTH_MARGIN) < {1'b0, m_d.depth}) &&
		(m_d.gen == gen);
	assign store_write = (req_q.op == OP_STORE) && !skip;
	assign new_move = (found && (req_q.best_move == 16'd0)) ? m_d.move : req_q.best_move;

	assign nd.gen   = gen;
	assign nd.bound = req_q.bound_kind;
	assign nd.depth = req_q.search_depth;
	assign nd.eval  = req_q.static_eval;
	assign nd.score = req_q.search_score;
	assign nd.move  = new_move;

	assign wr_addr = cmd.clr_en ? clr_addr : req_q.position_key[BUCKET_INDEX_BITS-1:0];
	assign wr_slot = cmd.clr_en ? '0 : {req_q.position_key ^ nd, nd};

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (req_q.op == OP_PROBE) begin
				rsp_q.hit         <= p_hit;
				rsp_q.found_move  <= p_d.move;
				rsp_q.found_score <= p_d.score;
				rsp_q.found_eval  <= p_d.eval;
				rsp_q.found_depth <= p_d.depth;
				rsp_q.found_bound <= p_d.bound;
			end else begin
				rsp_q.hit         <= store_write;
				rsp_q.found_move  <= '0;
				rsp_q.found_score <= '0;
				rsp_q.found_eval  <= '0;
				rsp_q.found_depth <= '0;
				rsp_q.found_bound <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_word        = rsp_q;
	assign rsp_valid       = rsp_valid_q;
	assign status.out_busy = rsp_valid_q && !rsp_ready;

	`BTT_ASSERT_NEXT(a_commit_valid, clk, arst_n, cmd.commit, rsp_valid, "word not presented")
	`BTT_ASSERT(a_one_way, clk, arst_n, cmd.clr_en || $onehot0(way_we), "store wrote two ways")
	`BTT_ASSERT(a_probe_nowrite, clk, arst_n, !(cmd.commit && !store_write && (way_we != '0)), "stray write")

endmodule

`default_nettype wire

/* src/bucketed_transposition_table.sv */
// Top level of the bucketed transposition table
//
//  channel | role   | moves
//  --------+--------+------------------------------------------------------
//  req     | sink   | probe or store word: op, key, move, score, eval, depth, bound
//  rsp     | source | one result word per request: hit and found entry fields
//  apb     | slave  | search_generation register at byte address 0
//
//  The accept cycle of a word reads the whole bucket from the way memories, the
//  next compares, selects a victim, writes one way back for a store that is not
//  skipped and loads the output register. A full output register holds the
//  compare state. After reset a clearing pass zeroes one bucket a cycle with
//  req.ready low; register writes are taken throughout.
`default_nettype none

module bucketed_transposition_table #(
	parameter int BUCKET_INDEX_BITS = 10,
	parameter int WAYS              = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	btt_req_if.sink                        req,
	btt_rsp_if.source                      rsp,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [btt_pkg::REG_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import btt_pkg::*;

	logic [5:0]                   gen_q;
	req_word_t                    req_word;
	rsp_word_t                    rsp_word;
	logic                         rsp_valid;
	ctrl_cmd_t                    cmd;
	dp_status_t                   status;
	logic [BUCKET_INDEX_BITS-1:0] clr_addr;
	logic                         req_ready;

	assign pready = 1'b1;
	assign prdata = (paddr[REG_ADDR_W-1] == REG_SEARCH_GENERATION) ? {26'd0, gen_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= '0;
		end else if (psel && penable && pwrite && pready &&
			(paddr[REG_ADDR_W-1] == REG_SEARCH_GENERATION)) begin
			gen_q <= pwdata[5:0];
		end
	end

	assign req_word.op           = req.op;
	assign req_word.position_key = req.position_key;
	assign req_word.best_move    = req.best_move;
	assign req_word.search_score = req.search_score;
	assign req_word.static_eval  = req.static_eval;
	assign req_word.search_depth = req.search_depth;
	assign req_word.bound_kind   = req.bound_kind;
	assign req.ready             = req_ready;

	assign rsp.valid       = rsp_valid;
	assign rsp.hit         = rsp_word.hit;
	assign rsp.found_move  = rsp_word.found_move;
	assign rsp.found_score = rsp_word.found_score;
	assign rsp.found_eval  = rsp_word.found_eval;
	assign rsp.found_depth = rsp_word.found_depth;
	assign rsp.found_bound = rsp_word.found_bound;

	btt_ctrl #(
		.BUCKET_INDEX_BITS(BUCKET_INDEX_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req_ready),
		.status   (status),
		.cmd      (cmd),
		.clr_addr (clr_addr)
	);

	btt_dpath #(
		.BUCKET_INDEX_BITS(BUCKET_INDEX_BITS),
		.WAYS             (WAYS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_word (req_word),
		.gen      (gen_q),
		.cmd      (cmd),
		.clr_addr (clr_addr),
		.rsp_word (rsp_word),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp.ready),
		.status   (status)
	);

endmodule

`default_nettype wire

/* dv/bucketed_transposition_table_checker.sv */
// Checker for the transposition table: predicts each result word and compares it field by field
module bucketed_transposition_table_checker #(
	parameter int BUCKET_INDEX_BITS = 10,
	parameter int WAYS              = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	btt_req_if                             req,
	btt_rsp_if                             rsp,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [btt_pkg::REG_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	input  logic                           pready,
	output int                             errors,
	output int                             outstanding,
	output int                             probe_hits,
	output int                             stores_skipped
);
	import btt_pkg::*;

	localparam int TABLE_SLOTS     = (1 << BUCKET_INDEX_BITS) * WAYS;
	localparam int AGE_WEIGHT      = 8;
	localparam int NO_VICTIM_SCORE = 1 << 30;
	localparam int REPORT_CAP      = 40;

	logic [63:0] slot_check [TABLE_SLOTS];
	entry_data_t slot_data  [TABLE_SLOTS];
	logic [5:0]  cur_gen;
	rsp_word_t   expected_words [$];
	int          n_errors;
	int          n_probe_hits;
	int          n_skips;

	assign errors         = n_errors;
	assign probe_hits     = n_probe_hits;
	assign stores_skipped = n_skips;

	function automatic rsp_word_t probe_or_store(input req_word_t w);
		rsp_word_t   res;
		entry_data_t d;
		entry_data_t nd;
		logic [15:0] mv;
		logic [5:0]  age;
		int          base;
		int          chosen;
		int          worst;
		int          value;
		res    = '0;
		base   = int'(w.position_key[BUCKET_INDEX_BITS-1:0]) * WAYS;
		mv     = w.best_move;
		chosen = 0;
		worst  = NO_VICTIM_SCORE;
		if (w.op == OP_PROBE) begin
			for (int i = 0; i < WAYS; i++) begin
				d = slot_data[base + i];
				if (d != '0 && (slot_check[base + i] ^ d) == w.position_key) begin
					res.hit         = 1'b1;
					res.found_move  = d.move;
					res.found_score = d.score;
					res.found_eval  = d.eval;
					res.found_depth = d.depth;
					res.found_bound = d.bound;
					return res;
				end
			end
			return res;
		end
		for (int i = 0; i < WAYS; i++) begin
			d = slot_data[base + i];
			if ((slot_check[base + i] ^ d) == w.position_key) begin
				if (mv == '0)
					mv = d.move;
				if (w.bound_kind != EXACT_BOUND
						&& int'(w.search_depth) + int'(DEPTH_MARGIN) < int'(d.depth)
						&& d.gen == cur_gen)
					return res;
				chosen = i;
				break;
			end
			if (d == '0) begin
				value = int'(EMPTY_SCORE);
			end else begin
				age   = cur_gen - d.gen;
				value = int'(d.depth) - AGE_WEIGHT * int'(age);
			end
			if (value < worst) begin
				worst  = value;
				chosen = i;
			end
		end
		nd.gen   = cur_gen;
		nd.bound = w.bound_kind;
		nd.depth = w.search_depth;
		nd.eval  = w.static_eval;
		nd.score = w.search_score;
		nd.move  = mv;
		slot_data[base + chosen]  = nd;
		slot_check[base + chosen] = w.position_key ^ nd;
		res.hit = 1'b1;
		return res;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			n_errors++;
			if (n_errors <= REPORT_CAP)
				$display("%0t: %s expected %h, got %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		req_word_t w;
		rsp_word_t got;
		rsp_word_t want;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				slot_check[i] = '0;
				slot_data[i]  = '0;
			end
			cur_gen = '0;
			expected_words.delete();
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got = '{hit: rsp.hit, found_move: rsp.found_move, found_score: rsp.found_score,
					found_eval: rsp.found_eval, found_depth: rsp.found_depth,
					found_bound: rsp.found_bound};
				if (expected_words.size() == 0) begin
					n_errors++;
					if (n_errors <= REPORT_CAP)
						$display("%0t: result word %h expected none", $time, got);
				end else begin
					want = expected_words.pop_front();
					check_field("hit", 16'(want.hit), 16'(got.hit));
					check_field("found_move", want.found_move, got.found_move);
					check_field("found_score", want.found_score, got.found_score);
					check_field("found_eval", want.found_eval, got.found_eval);
					check_field("found_depth", 16'(want.found_depth), 16'(got.found_depth));
					check_field("found_bound", 16'(want.found_bound), 16'(got.found_bound));
				end
			end
			if (req.valid && req.ready) begin
				w = '{op: req.op, position_key: req.position_key, best_move: req.best_move,
					search_score: req.search_score, static_eval: req.static_eval,
					search_depth: req.search_depth, bound_kind: req.bound_kind};
				want = probe_or_store(w);
				if (w.op == OP_PROBE && want.hit)
					n_probe_hits++;
				if (w.op == OP_STORE && !want.hit)
					n_skips++;
				expected_words.push_back(want);
			end
			if (psel && penable && pwrite && pready
					&& paddr[REG_ADDR_W-1:2] == REG_SEARCH_GENERATION)
				cur_gen = pwdata[5:0];
			outstanding <= expected_words.size();
		end
	end

endmodule

/* dv/bucketed_transposition_table_tb.sv */
// Testbench top for the transposition table: clock, reset, stimulus, register writes and verdict
module bucketed_transposition_table_tb;
	import btt_pkg::*;

	localparam int BUCKET_INDEX_BITS = 10;
	localparam int WAYS              = 4;
	localparam int HALF_PERIOD       = 10;
	localparam int RESET_CYCLES      = 11;
	localparam int PHASES            = 8;
	localparam int WORDS_PER_PHASE   = 135;
	localparam int CYCLE_LIMIT       = 400000;
	localparam int POOL_BUCKETS      = 16;
	localparam int POOL_KEYS         = 6;

	localparam logic [REG_ADDR_W-1:0] ADDR_SEARCH_GENERATION = {REG_SEARCH_GENERATION, 2'b00};
	localparam logic [REG_ADDR_W-1:0] ADDR_UNMAPPED          = {~REG_SEARCH_GENERATION, 2'b00};
	localparam logic [1:0]            BOUND_INEXACT          = 2'd0;

	typedef enum int {RX_OPEN, RX_CHOPPY, RX_CLOGGED} rx_mode_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [REG_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	int errors;
	int outstanding;
	int probe_hits;
	int stores_skipped;
	int cycles;
	int words_sent;
	int burst_left;
	int rx_left;
	rx_mode_t rx_mode;

	logic [63:0] key_pool [POOL_BUCKETS][POOL_KEYS];
	logic [5:0]  gen_plan [PHASES];
	req_word_t   directed_words [$];

	btt_req_if req_ch ();
	btt_rsp_if rsp_ch ();

	bucketed_transposition_table #(
		.BUCKET_INDEX_BITS(BUCKET_INDEX_BITS),
		.WAYS(WAYS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	bucketed_transposition_table_checker #(
		.BUCKET_INDEX_BITS(BUCKET_INDEX_BITS),
		.WAYS(WAYS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.errors(errors),
		.outstanding(outstanding),
		.probe_hits(probe_hits),
		.stores_skipped(stores_skipped)
	);

	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
			$display("bucketed_transposition_table: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(2));
			rx_left = $urandom_range(10, 80);
		end
		rx_left--;
		case (rx_mode)
			RX_OPEN: begin
				rsp_ch.ready <= 1'b1;
			end
			RX_CHOPPY: begin
				rsp_ch.ready <= ($urandom_range(1) == 1);
			end
			default: begin
				rsp_ch.ready <= ($urandom_range(5) == 0);
			end
		endcase
	end

	function automatic req_word_t make_word(input logic op, input logic [63:0] key,
			input logic [15:0] mv, input logic [15:0] sc, input logic [15:0] ev,
			input logic [7:0] dp, input logic [1:0] bd);
		req_word_t w;
		w = '{op: op, position_key: key, best_move: mv, search_score: sc, static_eval: ev,
			search_depth: dp, bound_kind: bd};
		return w;
	endfunction

	function automatic logic [63:0] key_in_bucket(input int bucket);
		logic [63:0] k;
		k = {$urandom, $urandom};
		k[BUCKET_INDEX_BITS-1:0] = BUCKET_INDEX_BITS'(bucket);
		return k;
	endfunction

	function automatic req_word_t random_word();
		req_word_t w;
		int        pick;
		pick           = $urandom_range(99);
		w.op           = ($urandom_range(1) == 1) ? OP_STORE : OP_PROBE;
		w.position_key = key_pool[$urandom_range(POOL_BUCKETS - 1)][$urandom_range(POOL_KEYS - 1)];
		if (pick >= 92)
			w.position_key = {$urandom, $urandom};
		else if (pick >= 85)
			w.position_key[63:BUCKET_INDEX_BITS] = (64 - BUCKET_INDEX_BITS)'({$urandom, $urandom});
		w.best_move    = ($urandom_range(3) == 0) ? 16'h0000 : 16'($urandom);
		w.search_score = ($urandom_range(9) == 0) ? {$urandom_range(1) == 1, {15{1'b0}}}
			: 16'($urandom);
		w.static_eval  = ($urandom_range(9) == 0) ? {1'b0, {15{1'b1}}} : 16'($urandom);
		pick = $urandom_range(9);
		if (pick < 4)
			w.search_depth = 8'($urandom_range(12));
		else if (pick == 4)
			w.search_depth = ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
		else
			w.search_depth = 8'($urandom);
		w.bound_kind = 2'($urandom_range(3));
		return w;
	endfunction

	task automatic send_word(input req_word_t w);
		req_ch.valid        <= 1'b1;
		req_ch.op           <= w.op;
		req_ch.position_key <= w.position_key;
		req_ch.best_move    <= w.best_move;
		req_ch.search_score <= w.search_score;
		req_ch.static_eval  <= w.static_eval;
		req_ch.search_depth <= w.search_depth;
		req_ch.bound_kind   <= w.bound_kind;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic pace_and_send(input req_word_t w);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		send_word(w);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_ADDR_W-1:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [63:0] k5 [5];
		logic [63:0] k7;
		logic [63:0] ones;
		arst_n              = 1'b0;
		words_sent          = 0;
		burst_left          = 0;
		req_ch.valid        <= 1'b0;
		req_ch.op           <= OP_PROBE;
		req_ch.position_key <= '0;
		req_ch.best_move    <= '0;
		req_ch.search_score <= '0;
		req_ch.static_eval  <= '0;
		req_ch.search_depth <= '0;
		req_ch.bound_kind   <= '0;
		psel                <= 1'b0;
		penable             <= 1'b0;
		pwrite              <= 1'b0;
		paddr               <= '0;
		pwdata              <= '0;

		for (int b = 0; b < POOL_BUCKETS; b++)
			for (int j = 0; j < POOL_KEYS; j++)
				key_pool[b][j] = key_in_bucket(b == 0 ? 0 : (b == 1 ? (1 << BUCKET_INDEX_BITS) - 1
					: $urandom_range((1 << BUCKET_INDEX_BITS) - 1)));
		gen_plan = '{6'd1, 6'd63, 6'd0, 6'd32, 6'd31, 6'd63, 6'($urandom), 6'($urandom)};

		for (int i = 0; i < 5; i++)
			k5[i] = key_in_bucket(5);
		k7   = key_in_bucket(7);
		ones = '1;
		directed_words = '{
			make_word(OP_PROBE, '0, 16'h0000, 16'h0000, 16'h0000, 8'd0, BOUND_INEXACT),
			make_word(OP_STORE, '0, 16'h0000, 16'h0000, 16'h0000, 8'd0, BOUND_INEXACT),
			make_word(OP_PROBE, '0, 16'h0000, 16'h0000, 16'h0000, 8'd0, BOUND_INEXACT),
			make_word(OP_STORE, '0, 16'h1234, 16'd100, 16'hFF9C, 8'd7, EXACT_BOUND),
			make_word(OP_PROBE, '0, 16'h0000, 16'h0000, 16'h0000, 8'd0, BOUND_INEXACT),
			make_word(OP_STORE, ones, 16'hFFFF, 16'h7FFF, 16'h8000, 8'hFF, EXACT_BOUND),
			make_word(OP_PROBE, ones, 16'h0000, 16'h0000, 16'h0000, 8'd0, BOUND_INEXACT),
			make_word(OP_STORE, ones, 16'h0000, 16'h0001, 16'h0001, 8'd0, BOUND_INEXACT),
			make_word(OP_STORE, ones, 16'h0000, 16'h8000, 16'h7FFF, 8'd0, EXACT_BOUND),
			make_word(OP_PROBE, ones, 16'h0000, 16'h0000, 16'h0000, 8'd0, BOUND_INEXACT),
			make_word(OP_PROBE, 64'(ones[BUCKET_INDEX_BITS-1:0]), 16'h0000, 16'h0000,
				16'h0000, 8'd0, BOUND_INEXACT),
			make_word(OP_STORE, k5[0], 16'h0101, 16'h8000, 16'h7FFF, 8'd10, BOUND_INEXACT),
			make_word(OP_STORE, k5[1], 16'h0202, 16'h0010, 16'hFFF0, 8'd20, BOUND_INEXACT),
			make_word(OP_STORE, k5[2], 16'h0303, 16'h0020, 16'hFFE0, 8'd30, BOUND_INEXACT),
			make_word(OP_STORE, k5[3], 16'h0404, 16'h0030, 16'hFFD0, 8'd40, BOUND_INEXACT),
			make_word(OP_STORE, k5[4], 16'h0505, 16'h0040, 16'hFFC0, 8'd5, BOUND_INEXACT),
			make_word(OP_PROBE, k5[0], 16'h0000, 16'h0000, 16'h0000, 8'd0, BOUND_INEXACT),
			make_word(OP_PROBE, k5[4], 16'h0000, 16'h0000, 16'h0000, 8'd0, BOUND_INEXACT),
			make_word(OP_PROBE, k5[1], 16'h0000, 16'h0000, 16'h0000, 8'd0, BOUND_INEXACT),
			make_word(OP_STORE, k7, 16'h0000, 16'h0000, 16'h0000, 8'd0, BOUND_INEXACT),
			make_word(OP_STORE, k7, 16'hBEEF, 16'hFFFF, 16'h0001, 8'd200, BOUND_INEXACT),
			make_word(OP_PROBE, k7, 16'h0000, 16'h0000, 16'h0000, 8'd0, BOUND_INEXACT)
		};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_words[i])
			pace_and_send(directed_words[i]);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			write_reg(ADDR_SEARCH_GENERATION, {26'($urandom), gen_plan[p]});
			if (p == 3)
				write_reg(ADDR_UNMAPPED, $urandom);
			for (int i = 0; i < WORDS_PER_PHASE; i++) begin
				pace_and_send(random_word());
				if (p == 4 && i == WORDS_PER_PHASE / 2)
					drain();
			end
			drain();
		end
		repeat (8) @(posedge clk);

		$display("sent %0d probe/store words over %0d generation settings",
			words_sent, PHASES + 1);
		$display("with wrap and one unmapped write; probes that hit: %0d", probe_hits);
		$display("stores held back by a deeper current entry: %0d", stores_skipped);
		if (errors == 0)
			$display("bucketed_transposition_table: match");
		else
			$display("bucketed_transposition_table: mismatch");
		$finish;
	end

endmodule
